@@ src/ry420_pkg.sv @@
// shared constants, types and register codes for the rgb to yuv 4:2:0 converter
`default_nettype none
package ry420_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int CFG_W     = 13;
  localparam int COL_W     = 12;
  localparam int ADDR_W    = 25;
  localparam int CHR_W     = 24;
  localparam int AREA_W    = 2 * CFG_W;
  localparam int REG_IDX_W = 2;
  localparam int PIX_W     = 8;
  localparam int PLANE_W   = 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LINE_PITCH   = 2'd2;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [CFG_W-1:0] RST_LINE_PITCH   = 13'd640;

  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  // sum widths
  localparam int MILLE_W = 18;
  localparam int SNUM_W  = 20;
  localparam int PCT_W   = 15;

  localparam int Y_R_MILLE = 299;
  localparam int Y_G_MILLE = 587;
  localparam int Y_B_MILLE = 114;
  localparam int U_R_MILLE = 147;
  localparam int U_G_MILLE = 287;
  localparam int U_B_MILLE = 436;
  localparam int V_R_MILLE = 615;
  localparam int V_G_MILLE = 515;
  localparam int V_B_MILLE = 100;
  localparam int C_OFFSET  = 128000;
  localparam int Y_R_PCT   = 30;
  localparam int Y_G_PCT   = 59;
  localparam int Y_B_PCT   = 11;

  // floor(n / 1000) = ((n >> 3) * 33555) >> 22, exact for n < 256000
  localparam int DIV1000_PRE   = 3;
  localparam int DIV1000_MUL   = 33555;
  localparam int DIV1000_SHIFT = 22;
  localparam int DIV1000_PW    = 31;
  localparam int SAT_LIMIT     = 256000;
  // floor(n / 100) = ((n >> 2) * 10486) >> 18, exact for n < 25600
  localparam int DIV100_PRE    = 2;
  localparam int DIV100_MUL    = 10486;
  localparam int DIV100_SHIFT  = 18;
  localparam int DIV100_PW     = 27;

  typedef struct packed {
    logic [ADDR_W-1:0] luma_addr;
    logic [ADDR_W-1:0] chroma_off;
    logic              chroma;
  } pix_tag_t;

  typedef struct packed {
    logic [ADDR_W-1:0] luma_addr;
    logic [ADDR_W-1:0] u_addr;
    logic [ADDR_W-1:0] v_addr;
    logic [PIX_W-1:0]  y;
    logic [PIX_W-1:0]  u;
    logic [PIX_W-1:0]  v;
    logic              chroma;
  } pix_res_t;

endpackage
`default_nettype wire

@@ src/ry420_addr.sv @@
// configuration registers, raster counters and destination address generation
`default_nettype none
module ry420_addr (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  input  wire logic [ry420_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [ry420_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                            pix_accept,
  output ry420_pkg::pix_tag_t                  tag,
  output logic [ry420_pkg::AREA_W-1:0]         area
);

  logic [ry420_pkg::CFG_W-1:0]  frame_width_r;
  logic [ry420_pkg::CFG_W-1:0]  frame_height_r;
  logic [ry420_pkg::CFG_W-1:0]  line_pitch_r;
  logic [ry420_pkg::AREA_W-1:0] area_r;

  logic [ry420_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [ry420_pkg::COL_W-1:0]  row_r, row_nxt;
  logic [ry420_pkg::ADDR_W-1:0] lrb_r, lrb_nxt;
  logic [ry420_pkg::CHR_W-1:0]  cro_r, cro_nxt;

  logic [ry420_pkg::CFG_W:0]    w_sum;
  logic [ry420_pkg::CFG_W:0]    w_round;
  logic [ry420_pkg::CFG_W-1:0]  eff_w, eff_h, eff_p;
  logic [ry420_pkg::COL_W-1:0]  col_inc, row_inc;
  logic                         end_row, end_frame;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= ry420_pkg::RST_FRAME_WIDTH;
      frame_height_r <= ry420_pkg::RST_FRAME_HEIGHT;
      line_pitch_r   <= ry420_pkg::RST_LINE_PITCH;
    end else if (cfg_valid) begin
      case (cfg_index)
        ry420_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        ry420_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        ry420_pkg::REG_LINE_PITCH:   line_pitch_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    w_sum   = {1'b0, frame_width_r} + (ry420_pkg::CFG_W+1)'(1);
    w_round = {w_sum[ry420_pkg::CFG_W:1], 1'b0};
    if (w_round < (ry420_pkg::CFG_W+1)'(2)) begin
      eff_w = ry420_pkg::CFG_W'(2);
    end else if (w_round > (ry420_pkg::CFG_W+1)'(ry420_pkg::MAX_WIDTH)) begin
      eff_w = ry420_pkg::CFG_W'((ry420_pkg::MAX_WIDTH / 2) * 2);
    end else begin
      eff_w = w_round[ry420_pkg::CFG_W-1:0];
    end
    if (frame_height_r == '0) begin
      eff_h = ry420_pkg::CFG_W'(1);
    end else if (frame_height_r > ry420_pkg::CFG_W'(ry420_pkg::MAX_HEIGHT)) begin
      eff_h = ry420_pkg::CFG_W'(ry420_pkg::MAX_HEIGHT);
    end else begin
      eff_h = frame_height_r;
    end
    eff_p = (line_pitch_r < eff_w) ? eff_w : line_pitch_r;
  end

  // luma plane size, settles while the block is idle after a write
  always_ff @(posedge clk) begin
    area_r <= ry420_pkg::AREA_W'(eff_p) * ry420_pkg::AREA_W'(eff_h);
  end

  always_comb begin
    col_inc   = col_r + ry420_pkg::COL_W'(1);
    row_inc   = row_r + ry420_pkg::COL_W'(1);
    end_row   = (col_inc == '0) || ({1'b0, col_inc} >= eff_w);
    end_frame = (row_inc == '0) || ({1'b0, row_inc} >= eff_h);
    col_nxt   = col_inc;
    row_nxt   = row_r;
    lrb_nxt   = lrb_r;
    cro_nxt   = cro_r;
    if (end_row) begin
      col_nxt = '0;
      lrb_nxt = lrb_r + ry420_pkg::ADDR_W'(eff_p);
      if (row_r[0]) begin
        cro_nxt = cro_r + ry420_pkg::CHR_W'(eff_p >> 1);
      end
      row_nxt = row_inc;
      if (end_frame) begin
        row_nxt = '0;
        lrb_nxt = '0;
        cro_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      lrb_r <= '0;
      cro_r <= '0;
    end else if (pix_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      lrb_r <= lrb_nxt;
      cro_r <= cro_nxt;
    end
  end

  always_comb begin
    tag.luma_addr  = lrb_r + ry420_pkg::ADDR_W'(col_r);
    tag.chroma_off = ry420_pkg::ADDR_W'(cro_r) + ry420_pkg::ADDR_W'(col_r >> 1);
    tag.chroma     = !row_r[0] && !col_r[0];
  end

  assign area = area_r;

endmodule
`default_nettype wire

@@ src/ry420_conv.sv @@
// two stage color conversion datapath: weighted sums, then scaling and saturation
`default_nettype none
module ry420_conv (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ry420_pkg::PIX_W-1:0]    in_blue,
  input  wire logic [ry420_pkg::PIX_W-1:0]    in_green,
  input  wire logic [ry420_pkg::PIX_W-1:0]    in_red,
  input  wire ry420_pkg::pix_tag_t            in_tag,
  input  wire logic [ry420_pkg::AREA_W-1:0]   area,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output ry420_pkg::pix_res_t                 res
);

  function automatic logic [ry420_pkg::PIX_W-1:0] div1000_sat(
    input logic [ry420_pkg::SNUM_W-1:0] num
  );
    logic [ry420_pkg::DIV1000_PW-1:0] prod;
    logic [ry420_pkg::PIX_W-1:0]      q;
    prod = ry420_pkg::DIV1000_PW'(num[ry420_pkg::MILLE_W-1:ry420_pkg::DIV1000_PRE]) *
           ry420_pkg::DIV1000_PW'(ry420_pkg::DIV1000_MUL);
    q    = prod[ry420_pkg::DIV1000_SHIFT +: ry420_pkg::PIX_W];
    if (num[ry420_pkg::SNUM_W-1]) begin
      div1000_sat = '0;
    end else if (num >= ry420_pkg::SNUM_W'(ry420_pkg::SAT_LIMIT)) begin
      div1000_sat = '1;
    end else begin
      div1000_sat = q;
    end
  endfunction

  logic                          s1_valid_r;
  logic [ry420_pkg::PIX_W-1:0]   s1_b_r, s1_g_r, s1_r_r;
  ry420_pkg::pix_tag_t           s1_tag_r;

  logic                          s2_valid_r;
  logic [ry420_pkg::MILLE_W-1:0] s2_ym_r, s2_un_r;
  logic [ry420_pkg::SNUM_W-1:0]  s2_vn_r;
  logic [ry420_pkg::PCT_W-1:0]   s2_yp_r;
  ry420_pkg::pix_tag_t           s2_tag_r;

  logic [ry420_pkg::MILLE_W-1:0] ym, un;
  logic [ry420_pkg::SNUM_W-1:0]  vn;
  logic [ry420_pkg::PCT_W-1:0]   yp;
  logic                          s2_free, s1_move;

  logic [ry420_pkg::DIV100_PW-1:0] yp_prod;
  logic [ry420_pkg::PIX_W-1:0]     yp_q, ym_q;
  logic [ry420_pkg::AREA_W-1:0]    v_base;

  assign s2_free  = !s2_valid_r || res_ready;
  assign s1_move  = s1_valid_r && s2_free;
  assign in_ready = !s1_valid_r || s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_b_r   <= in_blue;
      s1_g_r   <= in_green;
      s1_r_r   <= in_red;
      s1_tag_r <= in_tag;
    end
    if (s1_move) begin
      s2_ym_r  <= ym;
      s2_un_r  <= un;
      s2_vn_r  <= vn;
      s2_yp_r  <= yp;
      s2_tag_r <= s1_tag_r;
    end
  end

  // weighted sums, chroma sums kept in modular arithmetic
  always_comb begin
    ym = ry420_pkg::MILLE_W'(ry420_pkg::Y_R_MILLE) * ry420_pkg::MILLE_W'(s1_r_r)
       + ry420_pkg::MILLE_W'(ry420_pkg::Y_G_MILLE) * ry420_pkg::MILLE_W'(s1_g_r)
       + ry420_pkg::MILLE_W'(ry420_pkg::Y_B_MILLE) * ry420_pkg::MILLE_W'(s1_b_r);
    un = ry420_pkg::MILLE_W'(ry420_pkg::C_OFFSET)
       + ry420_pkg::MILLE_W'(ry420_pkg::U_B_MILLE) * ry420_pkg::MILLE_W'(s1_b_r)
       - ry420_pkg::MILLE_W'(ry420_pkg::U_R_MILLE) * ry420_pkg::MILLE_W'(s1_r_r)
       - ry420_pkg::MILLE_W'(ry420_pkg::U_G_MILLE) * ry420_pkg::MILLE_W'(s1_g_r);
    vn = ry420_pkg::SNUM_W'(ry420_pkg::C_OFFSET)
       + ry420_pkg::SNUM_W'(ry420_pkg::V_R_MILLE) * ry420_pkg::SNUM_W'(s1_r_r)
       - ry420_pkg::SNUM_W'(ry420_pkg::V_G_MILLE) * ry420_pkg::SNUM_W'(s1_g_r)
       - ry420_pkg::SNUM_W'(ry420_pkg::V_B_MILLE) * ry420_pkg::SNUM_W'(s1_b_r);
    yp = ry420_pkg::PCT_W'(ry420_pkg::Y_R_PCT) * ry420_pkg::PCT_W'(s1_r_r)
       + ry420_pkg::PCT_W'(ry420_pkg::Y_G_PCT) * ry420_pkg::PCT_W'(s1_g_r)
       + ry420_pkg::PCT_W'(ry420_pkg::Y_B_PCT) * ry420_pkg::PCT_W'(s1_b_r);
  end

  always_comb begin
    yp_prod = ry420_pkg::DIV100_PW'(s2_yp_r[ry420_pkg::PCT_W-1:ry420_pkg::DIV100_PRE]) *
              ry420_pkg::DIV100_PW'(ry420_pkg::DIV100_MUL);
    yp_q    = yp_prod[ry420_pkg::DIV100_SHIFT +: ry420_pkg::PIX_W];
    ym_q    = div1000_sat(ry420_pkg::SNUM_W'(s2_ym_r));
    v_base  = area + (area >> 2);

    res.luma_addr = s2_tag_r.luma_addr;
    res.u_addr    = ry420_pkg::ADDR_W'(area) + s2_tag_r.chroma_off;
    res.v_addr    = ry420_pkg::ADDR_W'(v_base) + s2_tag_r.chroma_off;
    res.y         = s2_tag_r.chroma ? ym_q : yp_q;
    res.u         = div1000_sat(ry420_pkg::SNUM_W'(s2_un_r));
    res.v         = div1000_sat(s2_vn_r);
    res.chroma    = s2_tag_r.chroma;
  end

  assign res_valid = s2_valid_r;

endmodule
`default_nettype wire

@@ src/ry420_ser.sv @@
// result register that hands out the luma and chroma samples of a pixel one per transfer
`default_nettype none
module ry420_ser (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          res_valid,
  output logic                               res_ready,
  input  wire ry420_pkg::pix_res_t           res,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ry420_pkg::PLANE_W-1:0]      out_plane,
  output logic [ry420_pkg::ADDR_W-1:0]       out_addr,
  output logic [ry420_pkg::PIX_W-1:0]        out_sample,
  output logic                               out_last
);

  logic                            valid_r;
  logic [ry420_pkg::PLANE_W-1:0]   idx_r;
  ry420_pkg::pix_res_t             pix_r;

  always_comb begin
    case (idx_r)
      ry420_pkg::PLANE_Y: begin
        out_plane  = ry420_pkg::PLANE_Y;
        out_addr   = pix_r.luma_addr;
        out_sample = pix_r.y;
        out_last   = !pix_r.chroma;
      end
      ry420_pkg::PLANE_U: begin
        out_plane  = ry420_pkg::PLANE_U;
        out_addr   = pix_r.u_addr;
        out_sample = pix_r.u;
        out_last   = 1'b0;
      end
      default: begin
        out_plane  = ry420_pkg::PLANE_V;
        out_addr   = pix_r.v_addr;
        out_sample = pix_r.v;
        out_last   = 1'b1;
      end
    endcase
  end

  assign out_valid = valid_r;
  assign res_ready = !valid_r || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= ry420_pkg::PLANE_Y;
    end else if (res_ready) begin
      valid_r <= res_valid;
      idx_r   <= ry420_pkg::PLANE_Y;
    end else if (out_ready) begin
      idx_r   <= idx_r + ry420_pkg::PLANE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      pix_r <= res;
    end
  end

endmodule
`default_nettype wire

@@ src/rgb_to_yuv420_planar_top.sv @@
// top level of the rgb to planar yuv 4:2:0 converter
// usage:
//   in_* carries one rgb pixel per transfer in raster order; out_* carries
//   destination samples: luma for every pixel, plus one u and one v sample
//   for the first pixel of each horizontal pair on even rows, in the order
//   y, u, v with tlast on the final sample of the pixel
//   cfg_* writes frame width, frame height and line pitch; cfg_ready is
//   always high, write only while no pixel is in flight
//   path: the first sample of a pixel is offered from the result register, after
//   the pixel has passed the first and second conversion stage registers
//   throughput: the result register sends one sample per cycle while out_tready
//   is high, so a pixel with chroma has three samples and any other pixel one,
//   two samples per pixel on average over even rows and one on odd rows; input
//   is taken every cycle while the result register keeps up
//   reset: registers return to 640 x 480 with pitch 640, counters to the
//   top left corner of the frame, and the pipeline empties
//   stall: with out_tready low the result holds, the two conversion stages
//   fill, and then in_tready drops until the receiver takes samples again
`default_nettype none
module rgb_to_yuv420_planar_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [23:0]                     in_tdata,   // blue, green, red
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [39:0]                          out_tdata,  // byte_address, sample, zero pad
  output logic [ry420_pkg::PLANE_W-1:0]        out_tuser,  // plane
  output logic                                 out_tlast,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ry420_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [ry420_pkg::CFG_W-1:0]     cfg_data
);

  ry420_pkg::pix_tag_t              tag;
  ry420_pkg::pix_res_t              res;
  logic [ry420_pkg::AREA_W-1:0]     area;
  logic                             res_valid, res_ready;
  logic [ry420_pkg::ADDR_W-1:0]     out_addr;
  logic [ry420_pkg::PIX_W-1:0]      out_sample;

  assign cfg_ready = 1'b1;

  ry420_addr u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_accept (in_tvalid && in_tready),
    .tag        (tag),
    .area       (area)
  );

  ry420_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_blue   (in_tdata[7:0]),
    .in_green  (in_tdata[15:8]),
    .in_red    (in_tdata[23:16]),
    .in_tag    (tag),
    .area      (area),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ry420_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_plane  (out_tuser),
    .out_addr   (out_addr),
    .out_sample (out_sample),
    .out_last   (out_tlast)
  );

  assign out_tdata = {7'd0, out_sample, out_addr};

endmodule
`default_nettype wire
